[rtl/core/lis_pkg.sv]
// ============================================================================
// lis_pkg
// Shared types and constants for the longest increasing subsequence unit.
// ============================================================================
package lis_pkg;

  localparam int VALUE_W  = 32;
  localparam int LENGTH_W = 11;

  // Controller to datapath
  typedef struct packed {
    logic start;   // input transaction accepted, load key and search bounds
    logic step;    // one search step on the tail returned by the memory
    logic update;  // write the tail, update length, emit result on last
  } lis_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;        // table holds no tails, search is trivial
    logic search_done;  // bounds meet after the current step
    logic is_last;      // captured item closes the sequence
    logic out_free;     // result register can take a new result this cycle
  } lis_status_t;

endpackage

[rtl/core/lis_ctrl.sv]
// ============================================================================
// lis_ctrl
// Sequencer: accept, binary search steps, table update.
// ============================================================================
module lis_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lis_pkg::lis_status_t stat,
  output lis_pkg::lis_cmd_t    cmd
);
  import lis_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE
  } state_t;

  state_t state;

  always_comb begin
    cmd.start  = (state == ST_IDLE) && in_valid;
    cmd.step   = (state == ST_SEARCH);
    // hold in update while a closing result cannot be stored
    cmd.update = (state == ST_UPDATE) && (!stat.is_last || stat.out_free);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      in_stall <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state    <= stat.empty ? ST_UPDATE : ST_SEARCH;
            in_stall <= 1'b1;
          end
        end
        ST_SEARCH: begin
          if (stat.search_done) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (cmd.update) begin
            state    <= ST_IDLE;
            in_stall <= 1'b0;
          end
        end
        default: begin
          state    <= ST_IDLE;
          in_stall <= 1'b0;
        end
      endcase
    end
  end

endmodule

[rtl/core/lis_datapath.sv]
// ============================================================================
// lis_datapath
// Tail memory, search bounds, run length, overflow flag and result register.
// ============================================================================
module lis_datapath #(
  parameter int MAX_LEN = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [lis_pkg::VALUE_W-1:0]   value,
  input  logic                          last,
  input  lis_pkg::lis_cmd_t             cmd,
  output lis_pkg::lis_status_t          stat,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lis_pkg::LENGTH_W-1:0]  length,
  output logic                          overflow
);
  import lis_pkg::*;

  localparam int LEN_W  = $clog2(MAX_LEN + 1);
  localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam logic [LEN_W-1:0] MAX_LEN_C = LEN_W'(MAX_LEN);

  // tails stored with sign bit flipped: unsigned order equals signed order
  logic [VALUE_W-1:0] tail_mem [MAX_LEN];
  logic [VALUE_W-1:0] rd_data;
  logic [VALUE_W-1:0] key;
  logic               key_last;

  logic [LEN_W-1:0] lo;
  logic [LEN_W-1:0] hi;
  logic [LEN_W-1:0] run_length;
  logic             overflow_seen;

  logic [LEN_W-1:0] mid;
  logic             less;
  logic [LEN_W-1:0] lo_next;
  logic [LEN_W-1:0] hi_next;
  logic [LEN_W-1:0] mid_next;
  logic [ADDR_W-1:0] rd_idx;

  logic             full;
  logic             append;
  logic             wr_en;
  logic [LEN_W-1:0] run_upd;
  logic             ovf_upd;
  logic [LEN_W+LENGTH_W-1:0] length_wide;

  // one search step per cycle: rd_data is the tail at mid of current bounds
  always_comb begin
    mid  = lo + ((hi - lo) >> 1);
    less = (rd_data < key);
    if (cmd.start) begin
      lo_next = '0;
      hi_next = run_length;
    end else if (cmd.step) begin
      lo_next = less ? (mid + LEN_W'(1)) : lo;
      hi_next = less ? hi : mid;
    end else begin
      lo_next = lo;
      hi_next = hi;
    end
    mid_next = lo_next + ((hi_next - lo_next) >> 1);
    rd_idx   = mid_next[ADDR_W-1:0];
  end

  // lo is the insert position once the search has finished
  always_comb begin
    full        = (lo == MAX_LEN_C);
    append      = (lo == run_length) && !full;
    wr_en       = cmd.update && !full;
    run_upd     = append ? (run_length + LEN_W'(1)) : run_length;
    ovf_upd     = overflow_seen | full;
    length_wide = {{LENGTH_W{1'b0}}, run_upd};
  end

  always_comb begin
    stat.empty       = (run_length == '0);
    stat.search_done = (lo_next == hi_next);
    stat.is_last     = key_last;
    stat.out_free    = !out_valid || !out_stall;
  end

  always_ff @(posedge clk) begin
    rd_data <= tail_mem[rd_idx];
    if (wr_en) begin
      tail_mem[lo[ADDR_W-1:0]] <= key;
    end
  end

  always_ff @(posedge clk) begin
    lo <= lo_next;
    hi <= hi_next;
    if (cmd.start) begin
      key      <= {~value[VALUE_W-1], value[VALUE_W-2:0]};
      key_last <= last;
    end
    if (cmd.update && key_last) begin
      length   <= length_wide[LENGTH_W-1:0];
      overflow <= ovf_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_length    <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.update) begin
        run_length    <= key_last ? '0 : run_upd;
        overflow_seen <= key_last ? 1'b0 : ovf_upd;
      end
      if (cmd.update && key_last) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/core/longest_increasing_subsequence_unit.sv]
// ============================================================================
// longest_increasing_subsequence_unit
// Streaming longest strictly increasing subsequence length per sequence.
// ============================================================================
// Each input transaction carries one signed 32-bit element of a sequence;
// the transaction with last set closes it and yields one result transaction
// with the sequence's longest strictly increasing subsequence length and a
// flag telling whether an extension past MAX_LEN was dropped. The unit works
// on one element at a time: it accepts the element, runs the binary search
// against the tail memory at one search step per cycle (read port
// registered, next address chosen from the compare of the current tail;
// no search while the table is empty), then writes the tail. A closing
// element waits in its write step while a previous result is still
// pending. Input is accepted while a result waits to be taken. No
// clearing pass after reset: only tails below the current length are
// ever used in a compare.
// ============================================================================
module longest_increasing_subsequence_unit #(
  parameter int MAX_LEN = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lis_pkg::VALUE_W-1:0]   value,
  input  logic                          last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lis_pkg::LENGTH_W-1:0]  length,
  output logic                          overflow
);
  import lis_pkg::*;

  lis_cmd_t    cmd;
  lis_status_t stat;

  // Sequencer: idle -> search steps -> table write
  lis_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Tail memory, bounds, running length and result register
  lis_datapath #(
    .MAX_LEN (MAX_LEN)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .value     (value),
    .last      (last),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .length    (length),
    .overflow  (overflow)
  );

  // An accepted transaction keeps the input side busy in the next cycle
  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall
  ) else $error("input accepted again while element in flight");

  // A closing update never overwrites a result still waiting downstream
  a_no_result_overwrite: assert property (
    @(posedge clk) disable iff (rst)
    (cmd.update && stat.is_last) |-> stat.out_free
  ) else $error("pending result overwritten");

  // At most one datapath command per cycle
  a_one_command: assert property (
    @(posedge clk) disable iff (rst)
    $onehot0({cmd.start, cmd.step, cmd.update})
  ) else $error("conflicting datapath commands");

endmodule
